### rtl/spr_pkg.sv
// Shared types and constants for the stepper pulse ramp generator.
package spr_pkg;

  localparam int RAMP_STEPS = 6;
  localparam int TABLE_DEPTH = RAMP_STEPS + 1;
  localparam int RAMP_SHIFT = 6;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Ramp segment of a pulse, in priority order, ending with the cruise rate.
  typedef enum logic [2:0] {
    SEL_X6,
    SEL_X3,
    SEL_X2,
    SEL_X3_2,
    SEL_X12_10,
    SEL_X11_10,
    SEL_CRUISE
  } ramp_sel_t;

  // Smallest count at which the first pulse already falls in segment k.
  localparam logic [6:0] START_MIN [RAMP_STEPS] = '{7'd64, 7'd32, 7'd22, 7'd16, 7'd13, 7'd11};

  typedef struct packed {
    logic      tick;
    logic [1:0] axis;
    logic      zero_count;
    ramp_sel_t sel0;
  } prep_ctrl_t;

  typedef struct packed {
    ramp_sel_t next_sel;
    logic      last;
  } sched_t;

endpackage

### rtl/spr_prep.sv
// Input stage: registers an item along with its precomputed ramp limits and half-periods.
module spr_prep #(
  parameter int COUNT_WIDTH  = 24,
  parameter int PERIOD_WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic                     advance,
  input  logic                     operation,
  input  logic [1:0]               axis,
  input  logic [COUNT_WIDTH-1:0]   pulse_count,
  input  logic [PERIOD_WIDTH-1:0]  base_half_period,
  output logic                     a_valid,
  output spr_pkg::prep_ctrl_t      ctrl,
  output logic [COUNT_WIDTH-1:0]   count_q,
  output logic [COUNT_WIDTH-1:0]   lead_q [spr_pkg::RAMP_STEPS],
  output logic [COUNT_WIDTH-1:0]   tail_q [spr_pkg::RAMP_STEPS],
  output logic [PERIOD_WIDTH+2:0]  hp_q [spr_pkg::TABLE_DEPTH]
);
  import spr_pkg::*;

  localparam int HW        = PERIOD_WIDTH + 3;
  localparam int DIV_SHIFT = PERIOD_WIDTH + 8;
  localparam int RW        = PERIOD_WIDTH + 5;
  localparam int XW        = PERIOD_WIDTH + 4;
  localparam int PROD_W    = XW + RW;
  localparam int LW        = COUNT_WIDTH + RAMP_SHIFT;
  localparam logic [63:0] RECIP10_FULL = ((64'd1 << DIV_SHIFT) + 64'd9) / 64'd10;
  localparam logic [RW-1:0] RECIP10 = RECIP10_FULL[RW-1:0];

  logic [XW-1:0]          b12, b11;
  logic [PROD_W-1:0]      p12, p11;
  logic [HW-1:0]          x3;
  logic [HW-1:0]          hp_next [TABLE_DEPTH];
  logic [LW-1:0]          lprod [RAMP_STEPS];
  logic [LW-1:0]          tprod [RAMP_STEPS];
  logic [COUNT_WIDTH-1:0] lead_next [RAMP_STEPS];
  logic [COUNT_WIDTH-1:0] tail_next [RAMP_STEPS];
  ramp_sel_t              sel0;

  // Divide by ten as a multiply by a rounded-up reciprocal; exact over the input range.
  always_comb begin
    b12 = XW'({base_half_period, 3'b000}) + XW'({base_half_period, 2'b00});
    b11 = XW'({base_half_period, 3'b000}) + XW'({base_half_period, 1'b0})
        + XW'(base_half_period);
    p12 = PROD_W'(b12) * PROD_W'(RECIP10);
    p11 = PROD_W'(b11) * PROD_W'(RECIP10);
    x3  = HW'({base_half_period, 1'b0}) + HW'(base_half_period);
    if (base_half_period == '0) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        hp_next[i] = HW'(1);
      end
    end else begin
      hp_next[SEL_X6]     = HW'({base_half_period, 2'b00}) + HW'({base_half_period, 1'b0});
      hp_next[SEL_X3]     = x3;
      hp_next[SEL_X2]     = HW'({base_half_period, 1'b0});
      hp_next[SEL_X3_2]   = x3 >> 1;
      hp_next[SEL_X12_10] = HW'(p12[DIV_SHIFT +: PERIOD_WIDTH+1]);
      hp_next[SEL_X11_10] = HW'(p11[DIV_SHIFT +: PERIOD_WIDTH+1]);
      hp_next[SEL_CRUISE] = HW'(base_half_period);
    end
  end

  always_comb begin
    for (int k = 0; k < RAMP_STEPS; k++) begin
      lprod[k] = LW'(pulse_count) * LW'(k + 1);
      tprod[k] = LW'(pulse_count) * LW'(63 - k);
      lead_next[k] = lprod[k][RAMP_SHIFT +: COUNT_WIDTH];
      tail_next[k] = tprod[k][RAMP_SHIFT +: COUNT_WIDTH];
    end
  end

  // The first pulse lies in the earliest segment whose lead limit is already above zero.
  always_comb begin
    sel0 = SEL_CRUISE;
    for (int k = RAMP_STEPS - 1; k >= 0; k--) begin
      if (pulse_count >= COUNT_WIDTH'(START_MIN[k])) begin
        sel0 = ramp_sel_t'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (load) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl.tick       <= (operation == OP_TICK);
      ctrl.axis       <= axis;
      ctrl.zero_count <= (pulse_count == '0);
      ctrl.sel0       <= sel0;
      count_q         <= pulse_count;
      lead_q          <= lead_next;
      tail_q          <= tail_next;
      hp_q            <= hp_next;
    end
  end

endmodule

### rtl/spr_sched.sv
// Lookahead: finds the ramp segment of the next pulse and whether the current one is the last.
module spr_sched #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                   clk,
  input  logic [COUNT_WIDTH-1:0] pulse_index,
  input  logic [COUNT_WIDTH-1:0] total_pulses,
  input  logic [COUNT_WIDTH-1:0] lead_limits [spr_pkg::RAMP_STEPS],
  input  logic [COUNT_WIDTH-1:0] tail_limits [spr_pkg::RAMP_STEPS],
  output spr_pkg::sched_t        sched
);
  import spr_pkg::*;

  logic [COUNT_WIDTH-1:0] idx1;
  ramp_sel_t              sel;

  // Pulse boundaries are at least two items apart, so the registered lookahead is always ready.
  always_comb begin
    idx1 = pulse_index + COUNT_WIDTH'(1);
    sel  = SEL_CRUISE;
    for (int k = RAMP_STEPS - 1; k >= 0; k--) begin
      if (idx1 < lead_limits[k] || idx1 > tail_limits[k]) begin
        sel = ramp_sel_t'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    sched.next_sel <= sel;
    sched.last     <= (idx1 == total_pulses);
  end

endmodule

### rtl/spr_core.sv
// Move state, half-period counter and the result register.
module spr_core #(
  parameter int COUNT_WIDTH  = 24,
  parameter int PERIOD_WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     out_ready,
  input  spr_pkg::prep_ctrl_t      ctrl,
  input  logic [COUNT_WIDTH-1:0]   count_in,
  input  logic [COUNT_WIDTH-1:0]   lead_in [spr_pkg::RAMP_STEPS],
  input  logic [COUNT_WIDTH-1:0]   tail_in [spr_pkg::RAMP_STEPS],
  input  logic [PERIOD_WIDTH+2:0]  hp_in [spr_pkg::TABLE_DEPTH],
  input  spr_pkg::sched_t          sched,
  output logic [COUNT_WIDTH-1:0]   pulse_index,
  output logic [COUNT_WIDTH-1:0]   total_pulses,
  output logic [COUNT_WIDTH-1:0]   lead_limits [spr_pkg::RAMP_STEPS],
  output logic [COUNT_WIDTH-1:0]   tail_limits [spr_pkg::RAMP_STEPS],
  output logic                     out_valid,
  output logic                     step_x,
  output logic                     step_y,
  output logic                     step_z,
  output logic                     busy_res,
  output logic                     move_done
);
  import spr_pkg::*;

  localparam int HW = PERIOD_WIDTH + 3;

  logic [1:0]             active_axis, active_axis_next;
  logic [COUNT_WIDTH-1:0] total_pulses_next, pulse_index_next;
  logic                   line_level, line_level_next;
  logic                   running, running_next;
  logic [HW-1:0]          half_remaining, half_remaining_next, hr_dec;
  logic [HW-1:0]          cur_period, cur_period_next;
  logic [HW-1:0]          hp_table [TABLE_DEPTH];
  logic [HW-1:0]          start_hp, next_hp;
  logic                   load_move;
  logic                   done;

  always_comb begin
    case (ctrl.sel0)
      SEL_X6:     start_hp = hp_in[SEL_X6];
      SEL_X3:     start_hp = hp_in[SEL_X3];
      SEL_X2:     start_hp = hp_in[SEL_X2];
      SEL_X3_2:   start_hp = hp_in[SEL_X3_2];
      SEL_X12_10: start_hp = hp_in[SEL_X12_10];
      SEL_X11_10: start_hp = hp_in[SEL_X11_10];
      default:    start_hp = hp_in[SEL_CRUISE];
    endcase
    case (sched.next_sel)
      SEL_X6:     next_hp = hp_table[SEL_X6];
      SEL_X3:     next_hp = hp_table[SEL_X3];
      SEL_X2:     next_hp = hp_table[SEL_X2];
      SEL_X3_2:   next_hp = hp_table[SEL_X3_2];
      SEL_X12_10: next_hp = hp_table[SEL_X12_10];
      SEL_X11_10: next_hp = hp_table[SEL_X11_10];
      default:    next_hp = hp_table[SEL_CRUISE];
    endcase
  end

  always_comb begin
    active_axis_next    = active_axis;
    total_pulses_next   = total_pulses;
    pulse_index_next    = pulse_index;
    line_level_next     = line_level;
    running_next        = running;
    half_remaining_next = half_remaining;
    cur_period_next     = cur_period;
    load_move           = 1'b0;
    done                = 1'b0;
    hr_dec = (half_remaining != '0) ? half_remaining - HW'(1) : half_remaining;
    if (!ctrl.tick) begin
      // Starts while busy or for the unused axis code are dropped.
      if (!running && ctrl.axis <= AXIS_Z) begin
        if (ctrl.zero_count) begin
          line_level_next = 1'b0;
          done            = 1'b1;
        end else begin
          load_move           = 1'b1;
          active_axis_next    = ctrl.axis;
          total_pulses_next   = count_in;
          pulse_index_next    = '0;
          running_next        = 1'b1;
          line_level_next     = 1'b1;
          half_remaining_next = start_hp;
          cur_period_next     = start_hp;
        end
      end
    end else if (running) begin
      half_remaining_next = hr_dec;
      if (hr_dec == '0) begin
        if (line_level) begin
          line_level_next     = 1'b0;
          half_remaining_next = cur_period;
        end else begin
          pulse_index_next = pulse_index + COUNT_WIDTH'(1);
          if (sched.last) begin
            running_next = 1'b0;
            done         = 1'b1;
          end else begin
            line_level_next     = 1'b1;
            half_remaining_next = next_hp;
            cur_period_next     = next_hp;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_axis    <= AXIS_X;
      total_pulses   <= '0;
      pulse_index    <= '0;
      line_level     <= 1'b0;
      running        <= 1'b0;
      half_remaining <= '0;
      cur_period     <= '0;
      out_valid      <= 1'b0;
      step_x         <= 1'b0;
      step_y         <= 1'b0;
      step_z         <= 1'b0;
      busy_res       <= 1'b0;
      move_done      <= 1'b0;
    end else begin
      if (advance) begin
        active_axis    <= active_axis_next;
        total_pulses   <= total_pulses_next;
        pulse_index    <= pulse_index_next;
        line_level     <= line_level_next;
        running        <= running_next;
        half_remaining <= half_remaining_next;
        cur_period     <= cur_period_next;
        step_x    <= running_next && line_level_next && (active_axis_next == AXIS_X);
        step_y    <= running_next && line_level_next && (active_axis_next == AXIS_Y);
        step_z    <= running_next && line_level_next && (active_axis_next == AXIS_Z);
        busy_res  <= running_next;
        move_done <= done;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_move) begin
      lead_limits <= lead_in;
      tail_limits <= tail_in;
      hp_table    <= hp_in;
    end
  end

endmodule

### rtl/stepper_pulse_ramp_generator.sv
// An accepted item is registered in the input stage, then its result in the move state.
// The block takes one item per cycle while results are taken; while a result waits, the input stage
// holds one more item and then stalls its input.
// The ramp segment of the next pulse is looked up ahead from the stored limits and registered.
// Reset (rst, synchronous, active high) leaves the block idle with all step lines low
// and both stages empty.
module stepper_pulse_ramp_generator #(
  parameter int COUNT_WIDTH  = 24,
  parameter int PERIOD_WIDTH = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // axis, pulse_count, base_half_period (lowest bits first), zero filled to whole bytes
  input  logic [((2 + COUNT_WIDTH + PERIOD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // operation
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // step_x, step_y, step_z, busy_res (lowest bits first), zero filled
  output logic [7:0] m_tdata,
  // move_done
  output logic m_tlast
);
  import spr_pkg::*;

  logic                    load, advance, a_valid;
  prep_ctrl_t              ctrl;
  sched_t                  sched;
  logic [COUNT_WIDTH-1:0]  count_q, pulse_index, total_pulses;
  logic [COUNT_WIDTH-1:0]  lead_q [RAMP_STEPS];
  logic [COUNT_WIDTH-1:0]  tail_q [RAMP_STEPS];
  logic [COUNT_WIDTH-1:0]  lead_limits [RAMP_STEPS];
  logic [COUNT_WIDTH-1:0]  tail_limits [RAMP_STEPS];
  logic [PERIOD_WIDTH+2:0] hp_q [TABLE_DEPTH];
  logic                    step_x, step_y, step_z, busy_res;

  assign advance  = a_valid && (!m_tvalid || m_tready);
  assign s_tready = !a_valid || advance;
  assign load     = s_tvalid && s_tready;
  assign m_tdata  = {4'b0000, busy_res, step_z, step_y, step_x};

  spr_prep #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .PERIOD_WIDTH(PERIOD_WIDTH)
  ) u_prep (
    .clk             (clk),
    .rst             (rst),
    .load            (load),
    .advance         (advance),
    .operation       (s_tuser),
    .axis            (s_tdata[1:0]),
    .pulse_count     (s_tdata[2 +: COUNT_WIDTH]),
    .base_half_period(s_tdata[2 + COUNT_WIDTH +: PERIOD_WIDTH]),
    .a_valid         (a_valid),
    .ctrl            (ctrl),
    .count_q         (count_q),
    .lead_q          (lead_q),
    .tail_q          (tail_q),
    .hp_q            (hp_q)
  );

  spr_sched #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_sched (
    .clk         (clk),
    .pulse_index (pulse_index),
    .total_pulses(total_pulses),
    .lead_limits (lead_limits),
    .tail_limits (tail_limits),
    .sched       (sched)
  );

  spr_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .PERIOD_WIDTH(PERIOD_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .out_ready   (m_tready),
    .ctrl        (ctrl),
    .count_in    (count_q),
    .lead_in     (lead_q),
    .tail_in     (tail_q),
    .hp_in       (hp_q),
    .sched       (sched),
    .pulse_index (pulse_index),
    .total_pulses(total_pulses),
    .lead_limits (lead_limits),
    .tail_limits (tail_limits),
    .out_valid   (m_tvalid),
    .step_x      (step_x),
    .step_y      (step_y),
    .step_z      (step_z),
    .busy_res    (busy_res),
    .move_done   (m_tlast)
  );

endmodule

### test/stepper_pulse_ramp_checker.sv
// Result checker for the stepper pulse ramp generator: tracks the move state and compares items.
module stepper_pulse_ramp_checker #(
  parameter int COUNT_W  = 24,
  parameter int PERIOD_W = 14,
  parameter int DATA_W   = ((2 + COUNT_W + PERIOD_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic              s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [7:0]        m_tdata,
  input  logic              m_tlast,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spr_pkg::*;

  typedef struct packed {
    logic [7:0] lines;
    logic       done;
  } motor_out_t;

  motor_out_t expected_q[$];

  // Local copy of the move state.
  logic [1:0]          run_axis;
  logic [COUNT_W-1:0]  run_total;
  logic [COUNT_W-1:0]  run_index;
  logic                line_hi;
  int unsigned         half_left;
  logic [PERIOD_W-1:0] cruise;
  longint unsigned     lead_lim [RAMP_STEPS];
  longint unsigned     tail_lim [RAMP_STEPS];
  logic                moving;

  initial errors = 0;
  initial pending = 0;

  // Half-period of a pulse: the first ramp segment whose window holds the pulse wins.
  function automatic int unsigned half_for(logic [COUNT_W-1:0] idx);
    ramp_sel_t   seg;
    int unsigned b;
    int unsigned t;
    seg = SEL_CRUISE;
    for (int k = RAMP_STEPS - 1; k >= 0; k--)
      if (idx < lead_lim[k] || idx > tail_lim[k]) seg = ramp_sel_t'(k);
    b = cruise;
    case (seg)
      SEL_X6:     t = b * 6;
      SEL_X3:     t = b * 3;
      SEL_X2:     t = b * 2;
      SEL_X3_2:   t = (b * 3) / 2;
      SEL_X12_10: t = (b * 12) / 10;
      SEL_X11_10: t = (b * 11) / 10;
      default:    t = b;
    endcase
    if (t == 0) t = 1;
    return t;
  endfunction

  task automatic apply_item(logic op, logic [1:0] ax, logic [COUNT_W-1:0] cnt,
                            logic [PERIOD_W-1:0] base);
    motor_out_t r;
    logic       fin;
    fin = 1'b0;
    if (op == OP_START) begin
      // Starts while moving and starts on the unused axis code leave everything as it is.
      if (!moving && ax <= AXIS_Z) begin
        if (cnt == '0) begin
          line_hi = 1'b0;
          fin = 1'b1;
        end else begin
          run_axis = ax;
          run_total = cnt;
          cruise = base;
          for (int k = 0; k < RAMP_STEPS; k++) begin
            lead_lim[k] = (longint'(k + 1) * cnt) >> RAMP_SHIFT;
            tail_lim[k] = (longint'((1 << RAMP_SHIFT) - 1 - k) * cnt) >> RAMP_SHIFT;
          end
          run_index = '0;
          moving = 1'b1;
          line_hi = 1'b1;
          half_left = half_for('0);
        end
      end
    end else if (moving) begin
      if (half_left > 0) half_left--;
      if (half_left == 0) begin
        if (line_hi) begin
          line_hi = 1'b0;
          half_left = half_for(run_index);
        end else begin
          run_index = run_index + 1'b1;
          if (run_index >= run_total) begin
            moving = 1'b0;
            fin = 1'b1;
          end else begin
            line_hi = 1'b1;
            half_left = half_for(run_index);
          end
        end
      end
    end
    r.lines = '0;
    r.lines[0] = moving && run_axis == AXIS_X && line_hi;
    r.lines[1] = moving && run_axis == AXIS_Y && line_hi;
    r.lines[2] = moving && run_axis == AXIS_Z && line_hi;
    r.lines[3] = moving;
    r.done = fin;
    expected_q.push_back(r);
  endtask

  task automatic compare_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    motor_out_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none got data %02h last %b",
               $time, m_tdata, m_tlast);
      return;
    end
    want = expected_q.pop_front();
    compare_field("step_x", m_tdata[0], want.lines[0]);
    compare_field("step_y", m_tdata[1], want.lines[1]);
    compare_field("step_z", m_tdata[2], want.lines[2]);
    compare_field("busy_res", m_tdata[3], want.lines[3]);
    compare_field("tdata fill", m_tdata[7:4], want.lines[7:4]);
    compare_field("move_done", m_tlast, want.done);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      run_axis = '0;
      run_total = '0;
      run_index = '0;
      line_hi = 1'b0;
      half_left = 0;
      cruise = '0;
      moving = 1'b0;
      for (int k = 0; k < RAMP_STEPS; k++) begin
        lead_lim[k] = 0;
        tail_lim[k] = 0;
      end
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        apply_item(s_tuser, s_tdata[1:0], s_tdata[COUNT_W+1:2],
                   s_tdata[COUNT_W+PERIOD_W+1:COUNT_W+2]);
      if (m_tvalid && m_tready) check_result();
    end
    pending <= expected_q.size();
  end

endmodule

### test/tb_stepper_pulse_ramp_generator.sv
// Testbench top for the stepper pulse ramp generator: clock, reset, stimulus and verdict.
module tb_stepper_pulse_ramp_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import spr_pkg::*;

  localparam int COUNT_W   = 24;
  localparam int PERIOD_W  = 14;
  localparam int DATA_W    = ((2 + COUNT_W + PERIOD_W + 7) / 8) * 8;
  localparam logic [1:0] AXIS_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int TICK_CAP     = 5000;
  localparam int LONG_TICKS   = 260;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;
  int                errors;
  int                pending;

  bit burst = 1'b0;
  bit steady = 1'b0;
  int items_sent = 0;
  int dones_wanted = 0;
  int moves_finished = 0;
  int results_taken = 0;

  always #1 clk = ~clk;

  stepper_pulse_ramp_generator #(
    .COUNT_WIDTH(COUNT_W),
    .PERIOD_WIDTH(PERIOD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  stepper_pulse_ramp_checker #(
    .COUNT_W(COUNT_W),
    .PERIOD_W(PERIOD_W),
    .DATA_W(DATA_W)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .errors(errors),
    .pending(pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      moves_finished <= 0;
      results_taken <= 0;
    end else if (m_tvalid && m_tready) begin
      results_taken <= results_taken + 1;
      if (m_tlast) moves_finished <= moves_finished + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(logic op, logic [1:0] ax, logic [COUNT_W-1:0] cnt,
                           logic [PERIOD_W-1:0] base);
    int gap;
    gap = (burst || steady) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= DATA_W'({base, cnt, ax});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // A start sent while a move is known to be running; the block must drop it.
  task automatic send_busy_start();
    send_item(OP_START, 2'($urandom_range(0, 3)), COUNT_W'($urandom), PERIOD_W'($urandom));
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 2'($urandom_range(0, 3)), COUNT_W'($urandom), PERIOD_W'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Sends a start from idle; for a move that runs, ticks until its finish or TICK_CAP.
  task automatic run_move(logic [1:0] ax, logic [COUNT_W-1:0] cnt,
                          logic [PERIOD_W-1:0] base, bit busy_start);
    longint unsigned shortest;
    int ticks;
    // Every half-period lasts at least max(base, 1) ticks, so the move is surely
    // still running for this many ticks.
    shortest = 2 * longint'(cnt) * ((base == '0) ? 64'd1 : 64'(base));
    send_item(OP_START, ax, cnt, base);
    if (ax == AXIS_NONE) return;
    dones_wanted++;
    if (cnt == '0) return;
    if (busy_start) send_busy_start();
    ticks = 0;
    while (moves_finished < dones_wanted && ticks < TICK_CAP) begin
      if (ticks + 1 < shortest && $urandom_range(0, 24) == 0) begin
        send_busy_start();
      end else begin
        send_tick();
        ticks++;
      end
    end
  endtask

  task automatic random_move();
    logic [1:0]          ax;
    logic [COUNT_W-1:0]  cnt;
    logic [PERIOD_W-1:0] base;
    int                  r;
    ax = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 8) ax = AXIS_NONE;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      cnt = '0;
    end else if (r < 60) begin
      cnt = COUNT_W'($urandom_range(1, 12));
    end else if (r < 85) begin
      // Counts at and around those at which a ramp segment first covers the opening pulse.
      case ($urandom_range(0, 7))
        0: cnt = 11;
        1: cnt = 13;
        2: cnt = 16;
        3: cnt = 22;
        4: cnt = 32;
        5: cnt = 63;
        6: cnt = 64;
        default: cnt = 65;
      endcase
    end else begin
      cnt = COUNT_W'($urandom_range(13, 40));
    end
    r = $urandom_range(0, 99);
    if (cnt > 16) base = PERIOD_W'($urandom_range(0, 2));
    else if (r < 20) base = '0;
    else if (r < 60) base = 1;
    else if (r < 90) base = PERIOD_W'($urandom_range(2, 4));
    else base = PERIOD_W'($urandom_range(5, 12));
    // A zero count or an ignored start costs no ticks, so any period will do.
    if ((cnt == '0 || ax == AXIS_NONE) && $urandom_range(0, 1) == 0)
      base = PERIOD_W'($urandom);
    burst = ($urandom_range(0, 4) == 0);
    run_move(ax, cnt, base, $urandom_range(0, 9) == 0);
  endtask

  initial begin : stimulus
    int moves;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    send_tick();
    send_tick();
    run_move(AXIS_NONE, 5, 1, 1'b0);
    send_tick();
    run_move(AXIS_X, '0, '1, 1'b0);
    run_move(AXIS_Z, '0, 1, 1'b0);
    run_move(AXIS_X, 1, 1, 1'b0);
    run_move(AXIS_Y, 1, '0, 1'b0);
    run_move(AXIS_Z, 3, 2, 1'b0);
    run_move(AXIS_X, 5, 3, 1'b1);
    run_move(AXIS_Y, 2, 2, 1'b1);
    run_move(AXIS_Z, 11, 1, 1'b0);
    run_move(AXIS_X, 13, 1, 1'b0);
    run_move(AXIS_Y, 16, 1, 1'b0);
    run_move(AXIS_Z, 22, 1, 1'b0);
    run_move(AXIS_X, 32, 1, 1'b0);
    run_move(AXIS_Y, 64, 1, 1'b0);

    // Random part.
    moves = 0;
    while (items_sent < RANDOM_ITEMS - LONG_TICKS) begin
      random_move();
      moves++;
      if (moves == 12) drain();
    end
    burst = 1'b0;

    // A move at full count, so the tail limits use every count bit;
    // tick through the falling edge of its first, widest pulse.
    drain();
    steady = 1'b1;
    send_item(OP_START, 2'($urandom_range(0, 2)), '1, PERIOD_W'(40));
    for (int i = 0; i < LONG_TICKS; i++) begin
      if ($urandom_range(0, 49) == 0) send_busy_start();
      send_tick();
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin : result_side
    int gap;
    int quiet;
    bit held;
    held = 1'b0;
    quiet = 0;
    forever begin
      // One long hold-off so the block fills up and backs up its input.
      if (!held && results_taken >= 300) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (quiet == 0 && $urandom_range(0, 39) == 0) quiet = $urandom_range(20, 80);
      gap = (steady || quiet > 0) ? 0 : pick_gap();
      if (quiet > 0) quiet--;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
rtl/spr_pkg.sv
rtl/spr_prep.sv
rtl/spr_sched.sv
rtl/spr_core.sv
rtl/stepper_pulse_ramp_generator.sv
test/stepper_pulse_ramp_checker.sv
test/tb_stepper_pulse_ramp_generator.sv
